>>> rtl/ipsv_pkg.sv
package ipsv_pkg;

  localparam int DATA_W         = 16;
  localparam int TRIG_FRAC_BITS = 14;

  // datapath widths, worst case over every input bit pattern
  localparam int PROD_W   = 32;                         // 16x16 signed product
  localparam int AB_W     = 33;                         // alpha / beta
  localparam int TERM_W   = 51;                         // doubled Q16 terms
  localparam int MAG_W    = TERM_W - 1 - TRIG_FRAC_BITS; // |term| >> trig bits
  localparam int P100_W   = 23;                         // period * 100
  localparam int HALF_W   = MAG_W / 2;
  localparam int PP_W     = HALF_W + P100_W;
  localparam int M_W      = MAG_W + P100_W;
  localparam int DEN_SHIFT = 15;                        // 2^15 factor of the divisor
  localparam int DVD_W    = M_W - DEN_SHIFT;
  localparam int DVS_W    = 23;                         // vbus * 115
  localparam int QUO_W    = 38;
  localparam int REM0_W   = DVD_W - QUO_W;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;
  localparam int LANES    = 3;                          // X, Y, Z
  localparam int T_W      = QUO_W + 1;
  localparam int TIME_W   = 44;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [18:0] SQRT3_Q16        = 19'sd113512;
  localparam logic signed [18:0] THREE_HALVES_Q17 = 19'sd196608;
  localparam int PERIOD_SCALE = 100;
  localparam int BUS_SCALE    = 115;

  localparam logic [DATA_W-1:0] PERIOD_RESET = 16'd8400;
  localparam logic [DATA_W-1:0] RELOAD_RESET = 16'd4200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PWM_PERIOD   = 2'd0,
    REG_TIMER_RELOAD = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    SECT_ZERO = 3'd0,
    SECT_1    = 3'd1,
    SECT_2    = 3'd2,
    SECT_3    = 3'd3,
    SECT_4    = 3'd4,
    SECT_5    = 3'd5,
    SECT_6    = 3'd6
  } sector_e;

  // travels alongside the quotients
  typedef struct packed {
    sector_e          sector;
    logic [LANES-1:0] neg;
  } ipsv_side_t;

endpackage

>>> rtl/ipsv_front.sv
module ipsv_front import ipsv_pkg::*; (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [DATA_W-1:0]          volt_d_i,
  input  logic signed [DATA_W-1:0]          volt_q_i,
  input  logic signed [DATA_W-1:0]          angle_sin_i,
  input  logic signed [DATA_W-1:0]          angle_cos_i,
  input  logic        [DATA_W-1:0]          bus_voltage_i,
  input  logic        [DATA_W-1:0]          period_i,
  output logic                              valid_o,
  output logic [LANES-1:0][DVD_W-1:0]       dvd_o,
  output logic        [DVS_W-1:0]           dvs_o,
  output ipsv_side_t                        side_o
);

  localparam int FRONT_STAGES = 7;

  logic [FRONT_STAGES-1:0] vld_q;

  // stage 1: products, divisor
  logic signed [PROD_W-1:0] p_dc_q, p_qs_q, p_ds_q, p_qc_q;
  logic [DVS_W-1:0] dvs_q [FRONT_STAGES];
  logic [DATA_W-1:0] vbus;
  // stage 2: alpha / beta
  logic signed [AB_W-1:0] a_q, b_q;
  // stage 3: scaled terms
  logic signed [TERM_W-1:0] sa_q, sb_q, ha_q, bs_q;
  logic bpos_q;
  // stage 4: X, Y, Z and sector
  logic signed [TERM_W-1:0] term_q [LANES];
  sector_e sect4_q;
  logic signed [TERM_W-1:0] d1, d2;
  // stage 5..7
  logic [MAG_W-1:0] mag_q [LANES];
  ipsv_side_t side5_q, side6_q, side7_q;
  logic [PP_W-1:0] pp_lo_q [LANES];
  logic [PP_W-1:0] pp_hi_q [LANES];
  logic [DVD_W-1:0] dvd_q [LANES];
  logic [P100_W-1:0] p100;
  logic [TERM_W-1:0] absv [LANES];
  logic [M_W-1:0] m [LANES];

  assign vbus = (bus_voltage_i == '0) ? DATA_W'(1) : bus_voltage_i;
  assign p100 = P100_W'(period_i) * P100_W'(PERIOD_SCALE);
  assign d1   = sa_q - bs_q;
  assign d2   = -sa_q - bs_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      absv[l] = term_q[l][TERM_W-1] ? TERM_W'(-term_q[l]) : TERM_W'(term_q[l]);
      m[l]    = M_W'(pp_lo_q[l]) + (M_W'(pp_hi_q[l]) << HALF_W);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[FRONT_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_dc_q <= PROD_W'(volt_d_i) * PROD_W'(angle_cos_i);
      p_qs_q <= PROD_W'(volt_q_i) * PROD_W'(angle_sin_i);
      p_ds_q <= PROD_W'(volt_d_i) * PROD_W'(angle_sin_i);
      p_qc_q <= PROD_W'(volt_q_i) * PROD_W'(angle_cos_i);
      dvs_q[0] <= DVS_W'(vbus) * DVS_W'(BUS_SCALE);
      for (int s = 1; s < FRONT_STAGES; s++) begin
        dvs_q[s] <= dvs_q[s-1];
      end

      a_q <= AB_W'(p_dc_q) - AB_W'(p_qs_q);
      b_q <= AB_W'(p_ds_q) + AB_W'(p_qc_q);

      sa_q   <= TERM_W'(a_q) * TERM_W'(SQRT3_Q16);
      sb_q   <= TERM_W'(b_q) * TERM_W'(SQRT3_Q16);
      ha_q   <= TERM_W'(a_q) * TERM_W'(THREE_HALVES_Q17);
      bs_q   <= TERM_W'(b_q) <<< 16;
      bpos_q <= !b_q[AB_W-1] && (b_q != '0);

      term_q[0] <= sb_q <<< 1;
      term_q[1] <= ha_q + sb_q;
      term_q[2] <= sb_q - ha_q;
      sect4_q   <= sector_e'({!d2[TERM_W-1] && (d2 != '0),
                              !d1[TERM_W-1] && (d1 != '0), bpos_q});

      side5_q.sector <= sect4_q;
      for (int l = 0; l < LANES; l++) begin
        mag_q[l]       <= MAG_W'(absv[l] >> TRIG_FRAC_BITS);
        side5_q.neg[l] <= term_q[l][TERM_W-1];
        pp_lo_q[l]     <= PP_W'(mag_q[l][HALF_W-1:0]) * PP_W'(p100);
        pp_hi_q[l]     <= PP_W'(mag_q[l][MAG_W-1:HALF_W]) * PP_W'(p100);
        dvd_q[l]       <= DVD_W'(m[l] >> DEN_SHIFT);
      end
      side6_q <= side5_q;
      side7_q <= side6_q;
    end
  end

  assign valid_o = vld_q[FRONT_STAGES-1];
  assign dvs_o   = dvs_q[FRONT_STAGES-1];
  assign side_o  = side7_q;
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      dvd_o[l] = dvd_q[l];
    end
  end

endmodule

>>> rtl/ipsv_div.sv
module ipsv_div import ipsv_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [LANES-1:0][DVD_W-1:0] dvd_i,
  input  logic [DVS_W-1:0]            dvs_i,
  input  ipsv_side_t                  side_i,
  output logic                        valid_o,
  output logic [LANES-1:0][QUO_W-1:0] quo_o,
  output ipsv_side_t                  side_o
);

  // restoring division, two quotient bits per stage; w holds the dividend
  // bits still to come in its top and the quotient bits so far at its bottom
  logic [DIV_STAGES-1:0] vld_q;
  logic [DVS_W-1:0] rem_q [DIV_STAGES][LANES];
  logic [QUO_W-1:0] w_q   [DIV_STAGES][LANES];
  logic [DVS_W-1:0] dvs_q [DIV_STAGES];
  ipsv_side_t       side_q [DIV_STAGES];
  logic [DVS_W-1:0] rem_d [DIV_STAGES][LANES];
  logic [QUO_W-1:0] w_d   [DIV_STAGES][LANES];

  always_comb begin
    logic [DVS_W-1:0] rem;
    logic [QUO_W-1:0] w;
    logic [DVS_W-1:0] dv;
    logic [DVS_W:0]   trial;
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int l = 0; l < LANES; l++) begin
        if (s == 0) begin
          rem = DVS_W'(dvd_i[l][DVD_W-1 -: REM0_W]);
          w   = dvd_i[l][QUO_W-1:0];
          dv  = dvs_i;
        end else begin
          rem = rem_q[s-1][l];
          w   = w_q[s-1][l];
          dv  = dvs_q[s-1];
        end
        for (int j = 0; j < BITS_PER_STAGE; j++) begin
          trial = {rem, w[QUO_W-1]};
          if (trial >= {1'b0, dv}) begin
            rem = DVS_W'(trial - {1'b0, dv});
            w   = {w[QUO_W-2:0], 1'b1};
          end else begin
            rem = trial[DVS_W-1:0];
            w   = {w[QUO_W-2:0], 1'b0};
          end
        end
        rem_d[s][l] = rem;
        w_d[s][l]   = w;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DIV_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_q[s] <= rem_d[s];
        w_q[s]   <= w_d[s];
        if (s == 0) begin
          dvs_q[s]  <= dvs_i;
          side_q[s] <= side_i;
        end else begin
          dvs_q[s]  <= dvs_q[s-1];
          side_q[s] <= side_q[s-1];
        end
      end
    end
  end

  assign valid_o = vld_q[DIV_STAGES-1];
  assign side_o  = side_q[DIV_STAGES-1];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo_o[l] = w_q[DIV_STAGES-1][l];
    end
  end

endmodule

>>> rtl/ipsv_back.sv
module ipsv_back import ipsv_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [LANES-1:0][QUO_W-1:0] quo_i,
  input  ipsv_side_t                  side_i,
  input  logic [DATA_W-1:0]           period_i,
  input  logic [DATA_W-1:0]           reload_i,
  output logic                        valid_o,
  output logic [DATA_W-1:0]           compare_a_o,
  output logic [DATA_W-1:0]           compare_b_o,
  output logic [DATA_W-1:0]           compare_c_o,
  output logic [2:0]                  sector_code_o
);

  logic [2:0] vld_q;
  logic signed [T_W-1:0] tv [LANES];
  logic signed [T_W-1:0] t1_d, t2_d, t1_q, t2_q;
  sector_e sect1_q, sect2_q, sect3_q;
  logic signed [TIME_W-1:0] four_p;
  logic signed [TIME_W-1:0] ta_q, tb_q, tc_q;
  logic [DATA_W-1:0] ca, cb, cc;
  logic [DATA_W-1:0] cmp_a_q, cmp_b_q, cmp_c_q;

  // reload minus a time in sixteenth counts, floored, saturated to 0..reload
  function automatic logic [DATA_W-1:0] to_compare(logic signed [TIME_W-1:0] t,
                                                   logic [DATA_W-1:0] r);
    logic signed [TIME_W-1:0] c16;
    logic signed [TIME_W-1:0] c;
    c16 = $signed(TIME_W'({r, 4'b0000})) - t;
    c   = c16 >>> 4;
    if (c16[TIME_W-1] || c16 == '0) begin
      return '0;
    end else if (c > $signed(TIME_W'(r))) begin
      return r;
    end
    return c[DATA_W-1:0];
  endfunction

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      tv[l] = side_i.neg[l] ? -$signed({1'b0, quo_i[l]}) : $signed({1'b0, quo_i[l]});
    end
    case (side_i.sector)
      SECT_1: begin t1_d = tv[2];  t2_d = tv[1];  end
      SECT_2: begin t1_d = tv[1];  t2_d = -tv[0]; end
      SECT_3: begin t1_d = -tv[2]; t2_d = tv[0];  end
      SECT_4: begin t1_d = -tv[0]; t2_d = tv[2];  end
      SECT_5: begin t1_d = tv[0];  t2_d = -tv[1]; end
      SECT_6: begin t1_d = -tv[1]; t2_d = -tv[2]; end
      default: begin t1_d = '0;    t2_d = '0;     end
    endcase
  end

  assign four_p = $signed(TIME_W'({period_i, 2'b00}));
  assign ca = to_compare(ta_q, reload_i);
  assign cb = to_compare(tb_q, reload_i);
  assign cc = to_compare(tc_q, reload_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q    <= t1_d;
      t2_q    <= t2_d;
      sect1_q <= side_i.sector;

      ta_q    <= four_p - TIME_W'(t1_q) - TIME_W'(t2_q);
      tb_q    <= four_p + TIME_W'(t1_q) - TIME_W'(t2_q);
      tc_q    <= four_p + TIME_W'(t1_q) + TIME_W'(t2_q);
      sect2_q <= sect1_q;

      sect3_q <= sect2_q;
      case (sect2_q)
        SECT_1: begin cmp_a_q <= cb; cmp_b_q <= ca; cmp_c_q <= cc; end
        SECT_2: begin cmp_a_q <= ca; cmp_b_q <= cc; cmp_c_q <= cb; end
        SECT_4: begin cmp_a_q <= cc; cmp_b_q <= cb; cmp_c_q <= ca; end
        SECT_5: begin cmp_a_q <= cc; cmp_b_q <= ca; cmp_c_q <= cb; end
        SECT_6: begin cmp_a_q <= cb; cmp_b_q <= cc; cmp_c_q <= ca; end
        default: begin cmp_a_q <= ca; cmp_b_q <= cb; cmp_c_q <= cc; end
      endcase
    end
  end

  assign valid_o       = vld_q[2];
  assign compare_a_o   = cmp_a_q;
  assign compare_b_o   = cmp_b_q;
  assign compare_c_o   = cmp_c_q;
  assign sector_code_o = sect3_q;

endmodule

>>> rtl/inverse_park_space_vector_pwm.sv
// Throughput: one item per cycle; the whole pipeline advances together and
// holds only while a result sits on the output and out_stall_i is high.
// The 19-stage divider (two quotient bits per stage) sets the depth.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the
// period (8400) and reload (4200) registers.
module inverse_park_space_vector_pwm import ipsv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // item in
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] volt_d_i,
  input  logic signed [DATA_W-1:0] volt_q_i,
  input  logic signed [DATA_W-1:0] angle_sin_i,
  input  logic signed [DATA_W-1:0] angle_cos_i,
  input  logic        [DATA_W-1:0] bus_voltage_i,
  // item out
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic        [DATA_W-1:0] compare_a_o,
  output logic        [DATA_W-1:0] compare_b_o,
  output logic        [DATA_W-1:0] compare_c_o,
  output logic        [2:0]        sector_code_o,
  // register writes
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DATA_W-1:0]        cfg_data_i
);

  logic [DATA_W-1:0] period_q, reload_q;
  logic en;

  logic                        f_valid;
  logic [LANES-1:0][DVD_W-1:0] f_dvd;
  logic [DVS_W-1:0]            f_dvs;
  ipsv_side_t                  f_side;

  logic                        d_valid;
  logic [LANES-1:0][QUO_W-1:0] d_quo;
  ipsv_side_t                  d_side;

  // pipeline moves unless a finished item is held at the output
  assign en          = !out_valid_o || !out_stall_i;
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  // config registers; writes outside the map are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      reload_q <= RELOAD_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PWM_PERIOD:   period_q <= cfg_data_i;
        REG_TIMER_RELOAD: reload_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // inverse Park, sector tests, scaling by period: 7 stages
  ipsv_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (in_valid_i),
    .volt_d_i      (volt_d_i),
    .volt_q_i      (volt_q_i),
    .angle_sin_i   (angle_sin_i),
    .angle_cos_i   (angle_cos_i),
    .bus_voltage_i (bus_voltage_i),
    .period_i      (period_q),
    .valid_o       (f_valid),
    .dvd_o         (f_dvd),
    .dvs_o         (f_dvs),
    .side_o        (f_side)
  );

  // division by 115 * vbus for X, Y and Z side by side: 19 stages
  ipsv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .dvd_i   (f_dvd),
    .dvs_i   (f_dvs),
    .side_i  (f_side),
    .valid_o (d_valid),
    .quo_o   (d_quo),
    .side_o  (d_side)
  );

  // active times, centre-aligned times, compares: 3 stages, last is output reg
  ipsv_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (d_valid),
    .quo_i         (d_quo),
    .side_i        (d_side),
    .period_i      (period_q),
    .reload_i      (reload_q),
    .valid_o       (out_valid_o),
    .compare_a_o   (compare_a_o),
    .compare_b_o   (compare_b_o),
    .compare_c_o   (compare_c_o),
    .sector_code_o (sector_code_o)
  );

`ifndef ASSERT_OFF
  // input only held back by a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // zero vector: all three phases share one compare
  a_zero_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sector_code_o == SECT_ZERO) |->
      (compare_a_o == compare_b_o && compare_b_o == compare_c_o))
    else $error("zero vector with unequal compares");

  // beta positive rules out both sqrt3 tests passing together
  a_sector_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(&sector_code_o))
    else $error("impossible sector code");
`endif

endmodule
